// ----- sv/actr_pkg.sv -----
// ----------------------------------------------------------------------------
// actr_pkg: shared types, constants and AES functions
// S-box, round constants and the per-round helpers used by the round and
// key expansion logic.
// ----------------------------------------------------------------------------
package actr_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int AES_ROUNDS  = 10;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = 28;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    typedef logic [127:0] t_block;

    typedef struct packed {
        logic [63:0]      data_low;
        logic [63:0]      data_high;
        logic [63:0]      message_offset;
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] byte_count;
    } t_in;

    typedef struct packed {
        logic [63:0]      out_low;
        logic [63:0]      out_high;
        logic [CNT_W-1:0] out_count;
    } t_out;

    typedef struct packed {
        logic [63:0] data;
    } t_cfg;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [AES_ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block lives in bits 8*i+7:8*i.
    function automatic t_block aes_round(input t_block s, input t_block rk, input logic last);
        logic [7:0] sb [16];
        logic [7:0] t  [16];
        logic [7:0] m  [16];
        logic [7:0] a0, a1, a2, a3, all;
        t_block     r;
        for (int i = 0; i < 16; i++) begin
            sb[i] = SBOX[s[8*i +: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                t[row + 4*c] = sb[row + 4*((c + row) % 4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = t[4*c];
            a1  = t[4*c+1];
            a2  = t[4*c+2];
            a3  = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            m[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            m[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            m[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        for (int i = 0; i < 16; i++) begin
            r[8*i +: 8] = (last ? t[i] : m[i]) ^ rk[8*i +: 8];
        end
        return r;
    endfunction

    function automatic t_block key_step(input t_block k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
              SBOX[k[111:104]] ^ rc};
        w0 = k[31:0] ^ t;
        w1 = k[63:32] ^ w0;
        w2 = k[95:64] ^ w1;
        w3 = k[127:96] ^ w2;
        return {w3, w2, w1, w0};
    endfunction

endpackage

// ----- sv/actr_if.sv -----
// ----------------------------------------------------------------------------
// actr_if: valid/ready channel interfaces
// Data channels and the key write channel.
// ----------------------------------------------------------------------------
interface actr_in_if;
    logic           valid;
    logic           ready;
    actr_pkg::t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface actr_out_if;
    logic           valid;
    logic           ready;
    actr_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface actr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [actr_pkg::CFG_IDX_W:0]      index;
    logic [63:0]                       data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/actr_key_sched.sv -----
// ----------------------------------------------------------------------------
// actr_key_sched: round key expansion
// Holds the key and rebuilds all eleven round keys, one per cycle, after reset
// or a key write; a new key write restarts the rebuild.
// ----------------------------------------------------------------------------
module actr_key_sched (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic                 i_sel_high,
    input  logic [63:0]          i_data,
    output actr_pkg::t_block     o_rk [actr_pkg::AES_ROUNDS+1],
    output logic                 o_busy
);

    actr_pkg::t_block r_key;
    actr_pkg::t_block r_rk [actr_pkg::AES_ROUNDS+1];
    logic [3:0]       r_step;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_step <= 4'd0;
            r_busy <= 1'b1;
        end else if (i_wr) begin
            if (i_sel_high) begin
                r_key[127:64] <= i_data;
            end else begin
                r_key[63:0] <= i_data;
            end
            r_step <= 4'd0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_step == 4'(actr_pkg::AES_ROUNDS)) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_wr && r_busy) begin
            if (r_step == 4'd0) begin
                r_rk[0] <= r_key;
            end else begin
                r_rk[r_step] <= actr_pkg::key_step(r_rk[r_step - 4'd1],
                                                   actr_pkg::RCON[r_step - 4'd1]);
            end
        end
    end

    assign o_rk   = r_rk;
    assign o_busy = r_busy;

endmodule

// ----- sv/actr_pipe.sv -----
// ----------------------------------------------------------------------------
// actr_pipe: counter formation and AES round pipeline
// Stage 0 adds the counter, stages 1..10 run one round each, the last stage
// applies the keystream and byte mask. Whole pipe advances when the output
// slot is free or empty; input is held off while round keys rebuild.
// ----------------------------------------------------------------------------
module actr_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    actr_in_if.sink              s_in,
    actr_out_if.source           m_out,
    input  actr_pkg::t_block     i_rk [actr_pkg::AES_ROUNDS+1],
    input  logic                 i_key_rdy
);

    localparam int NS = actr_pkg::AES_ROUNDS + 2;

    typedef struct packed {
        logic [127:0]                 data;
        logic [actr_pkg::CNT_W-1:0]   cnt;
    } t_side;

    logic             r_vld   [NS];
    actr_pkg::t_block r_state [NS];
    t_side            r_side  [NS];
    actr_pkg::t_block w_ctr;
    logic             w_adv;
    logic [63:0]      w_sum;
    logic [4:0]       w_lim;
    actr_pkg::t_block w_res;

    assign w_adv      = !r_vld[NS-1] || m_out.ready;
    assign s_in.ready = w_adv && i_key_rdy;

    always_comb begin
        w_sum = s_in.payload.message_offset + 64'(s_in.payload.block_index);
        w_ctr = {w_sum, 64'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= s_in.valid && i_key_rdy;
            for (int i = 1; i < NS; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_state[0] <= w_ctr ^ i_rk[0];
            r_side[0]  <= '{data: {s_in.payload.data_high, s_in.payload.data_low},
                            cnt: s_in.payload.byte_count};
            for (int i = 1; i <= actr_pkg::AES_ROUNDS; i++) begin
                r_state[i] <= actr_pkg::aes_round(r_state[i-1], i_rk[i],
                                                  i == actr_pkg::AES_ROUNDS);
                r_side[i]  <= r_side[i-1];
            end
            r_state[NS-1] <= w_res;
            r_side[NS-1]  <= r_side[NS-2];
        end
    end

    always_comb begin
        w_lim = r_side[NS-2].cnt;
        for (int i = 0; i < 16; i++) begin
            w_res[8*i +: 8] = (5'(i) < w_lim) ?
                (r_side[NS-2].data[8*i +: 8] ^ r_state[NS-2][8*i +: 8]) : 8'h00;
        end
    end

    assign m_out.valid             = r_vld[NS-1];
    assign m_out.payload.out_low   = r_state[NS-1][63:0];
    assign m_out.payload.out_high  = r_state[NS-1][127:64];
    assign m_out.payload.out_count = r_side[NS-1].cnt;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.payload))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid && i_key_rdy |-> s_in.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !r_vld[NS-2] |=> !m_out.valid)
        else $error("result invented");

endmodule

// ----- sv/aes128_counter_keystream_xor.sv -----
// ----------------------------------------------------------------------------
// aes128_counter_keystream_xor: AES-128 counter-mode keystream XOR
// One 16-byte block per cycle when not held by the output or a key rebuild;
// pipeline stages: counter add, ten round stages, one mask stage. After reset
// or a key write the round keys rebuild, during which input is held off; write
// keys only while the pipe is empty.
// ----------------------------------------------------------------------------
module aes128_counter_keystream_xor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    actr_in_if.sink     s_in,
    actr_out_if.source  m_out,
    actr_cfg_if.sink    s_cfg
);

    actr_pkg::t_block w_rk [actr_pkg::AES_ROUNDS+1];
    logic             w_wr;
    logic             w_key_busy;

    assign s_cfg.ready = 1'b1;
    assign w_wr = s_cfg.valid && (s_cfg.index[actr_pkg::CFG_IDX_W] == 1'b0);

    actr_key_sched u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_sel_high (s_cfg.index[0] == actr_pkg::REG_KEY_HIGH),
        .i_data     (s_cfg.data),
        .o_rk       (w_rk),
        .o_busy     (w_key_busy)
    );

    actr_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (s_in),
        .m_out     (m_out),
        .i_rk      (w_rk),
        .i_key_rdy (!w_key_busy)
    );

endmodule
